>>> hdl/prt_pkg.sv
// Shared types and codes for the persistent reservation table.
// Used by the command front end, the engine, the top level and the checker.
package prt_pkg;

	typedef enum logic [2:0] {
		OP_REGISTER      = 3'd0,
		OP_REGISTER_IGN  = 3'd1,
		OP_RESERVE       = 3'd2,
		OP_RELEASE       = 3'd3,
		OP_CLEAR         = 3'd4,
		OP_PREEMPT       = 3'd5,
		OP_PREEMPT_ABORT = 3'd6,
		OP_INVALID       = 3'd7
	} op_t;

	localparam logic [1:0] KIND_FINAL = 2'd0;
	localparam logic [1:0] KIND_UA    = 2'd1;
	localparam logic [1:0] KIND_ABORT = 2'd2;

	localparam logic [2:0] ST_GOOD        = 3'd0;
	localparam logic [2:0] ST_CONFLICT    = 3'd1;
	localparam logic [2:0] ST_INV_RELEASE = 3'd2;
	localparam logic [2:0] ST_INV_FIELD   = 3'd3;
	localparam logic [2:0] ST_TABLE_FULL  = 3'd4;

	localparam logic [1:0] ATT_RES_RELEASED  = 2'd0;
	localparam logic [1:0] ATT_RES_PREEMPTED = 2'd1;
	localparam logic [1:0] ATT_REG_PREEMPTED = 2'd2;

	localparam logic [3:0] TYPE_WR_EXCL     = 4'd1;
	localparam logic [3:0] TYPE_EXCL_ACCESS = 4'd3;
	localparam logic [3:0] TYPE_WR_EXCL_RO  = 4'd5;
	localparam logic [3:0] TYPE_EXCL_RO     = 4'd6;
	localparam logic [3:0] TYPE_WR_EXCL_AR  = 4'd7;
	localparam logic [3:0] TYPE_EXCL_AR     = 4'd8;

	localparam int MAX_NOTICES = 32;
	localparam int NCNT_W      = 6;

	typedef struct packed {
		op_t         op;
		logic [63:0] ip;
		logic [63:0] tp;
		logic [15:0] rp;
		logic [1:0]  itf;
		logic [63:0] key;
		logic [63:0] sak;
		logic [3:0]  rtype;
		logic [3:0]  scope;
	} cmd_t;

endpackage

>>> hdl/persistent_reservation_table.sv
// Persistent reservation engine: a small command queue in front of a table-scanning engine.
// A command passes through these steps: the engine takes it, makes one pass over the
// registration table to look up the requester and a free slot, decides, makes a second pass
// that emits notices one per cycle while the output is not stalled (two per entry for
// preempt-and-abort), then emits the final status word. A command whose decision sets no
// notice mode skips the second pass. Both passes go through the single read port into the
// table. The front queue holds two commands, so new commands are taken while one is in
// progress.
// Depends on prt_pkg, prt_front and prt_engine.
module persistent_reservation_table #(
	parameter int MAX_REGISTRATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [2:0]  action,
	input  logic [63:0] initiator_port,
	input  logic [63:0] target_port,
	input  logic [15:0] relative_port,
	input  logic [1:0]  interface_req,
	input  logic [63:0] reservation_key,
	input  logic [63:0] service_key,
	input  logic [3:0]  res_type,
	input  logic [3:0]  scope,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  kind,
	output logic [2:0]  status,
	output logic [1:0]  attention,
	output logic [63:0] note_initiator,
	output logic [63:0] note_target,
	output logic [15:0] note_relport,
	output logic [1:0]  note_interface,
	output logic [31:0] generation,
	output logic        last
);

	prt_pkg::cmd_t in_cmd, q_cmd;
	logic          q_valid, q_take;

	always_comb begin
		in_cmd.op    = prt_pkg::OP_INVALID;
		in_cmd.ip    = initiator_port;
		in_cmd.tp    = target_port;
		in_cmd.rp    = relative_port;
		in_cmd.itf   = interface_req;
		in_cmd.key   = reservation_key;
		in_cmd.sak   = service_key;
		in_cmd.rtype = res_type;
		in_cmd.scope = scope;
	end

	prt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_valid),
		.in_ready  (cmd_ready),
		.in_cmd    (in_cmd),
		.in_action (action),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_cmd     (q_cmd)
	);

	prt_engine #(
		.N (MAX_REGISTRATIONS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_take     (q_take),
		.q_cmd      (q_cmd),
		.out_valid  (rsp_valid),
		.out_ready  (rsp_ready),
		.out_kind   (kind),
		.out_status (status),
		.out_att    (attention),
		.out_ip     (note_initiator),
		.out_tp     (note_target),
		.out_rp     (note_relport),
		.out_itf    (note_interface),
		.out_gen    (generation),
		.out_last   (last)
	);

endmodule

>>> hdl/prt_front.sv
// Command front end: classifies incoming words and queues them for the engine.
// Depends on prt_pkg.
module prt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  prt_pkg::cmd_t  in_cmd,
	input  logic [2:0]     in_action,
	output logic           q_valid,
	input  logic           q_take,
	output prt_pkg::cmd_t  q_cmd
);

	prt_pkg::cmd_t fifo_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	prt_pkg::cmd_t cls;
	logic          push, pop;

	always_comb begin
		cls = in_cmd;
		case (in_action)
			prt_pkg::OP_REGISTER: cls.op = prt_pkg::OP_REGISTER;
			prt_pkg::OP_REGISTER_IGN: cls.op = prt_pkg::OP_REGISTER_IGN;
			prt_pkg::OP_RESERVE: cls.op = prt_pkg::OP_RESERVE;
			prt_pkg::OP_RELEASE: cls.op = prt_pkg::OP_RELEASE;
			prt_pkg::OP_CLEAR: cls.op = prt_pkg::OP_CLEAR;
			prt_pkg::OP_PREEMPT: cls.op = prt_pkg::OP_PREEMPT;
			prt_pkg::OP_PREEMPT_ABORT: cls.op = prt_pkg::OP_PREEMPT_ABORT;
			default: cls.op = prt_pkg::OP_INVALID;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = fifo_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_take;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> hdl/prt_engine.sv
// Reservation engine: registration table, holder state, table scans and result register.
// Depends on prt_pkg.
module prt_engine #(
	parameter int N = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_take,
	input  prt_pkg::cmd_t  q_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     out_kind,
	output logic [2:0]     out_status,
	output logic [1:0]     out_att,
	output logic [63:0]    out_ip,
	output logic [63:0]    out_tp,
	output logic [15:0]    out_rp,
	output logic [1:0]     out_itf,
	output logic [31:0]    out_gen,
	output logic           out_last
);

	localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
	localparam int CNT_W = $clog2(N + 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_LOOK   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_SCAN   = 5'b01000,
		S_FINAL  = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		M_NONE   = 2'd0,
		M_OTHERS = 2'd1,
		M_PREEMPT = 2'd2
	} mode_t;

	typedef struct packed {
		logic [2:0] st;
		logic       gen_inc;
		logic       set_res;
		logic       drop_res;
		logic       set_holder;
		logic       inv_found;
		logic       upd_key;
		logic       write_new;
		logic       clr_all;
		mode_t      mode;
		logic [1:0] att;
		logic       ar;
	} dec_t;

	state_t state_q;
	prt_pkg::cmd_t cmd_q;

	logic        e_valid_q [N];
	logic [63:0] e_ip_q    [N];
	logic [63:0] e_tp_q    [N];
	logic [15:0] e_rp_q    [N];
	logic [1:0]  e_itf_q   [N];
	logic [63:0] e_key_q   [N];

	logic        is_res_q;
	logic [3:0]  h_type_q;
	logic [63:0] h_key_q, h_ip_q, h_tp_q;
	logic [15:0] h_rp_q;
	logic [1:0]  h_itf_q;
	logic [31:0] gen_q;

	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx, fidx_q, free_idx_q;
	logic             found_q, free_ok_q, other_q;
	logic [63:0]      fkey_q;
	logic [2:0]       st_q;
	mode_t            mode_q;
	logic [1:0]       att_q;
	logic             ar_q, clr_q, sub_q;
	logic [prt_pkg::NCNT_W-1:0] ncnt_q;

	logic        ov_q, last_q;
	logic [1:0]  kind_q, att_o_q, itf_o_q;
	logic [2:0]  st_o_q;
	logic [63:0] ip_o_q, tp_o_q;
	logic [15:0] rp_o_q;
	logic [31:0] gen_o_q;

	logic        rd_valid, same, hit, at_end, ld, capped;
	logic        emit, emit_last, adv, inv_now, sub_set;
	logic [1:0]  emit_kind, emit_att;
	dec_t        d;
	logic        reg_wk, hid, h_single, h_ro, h_ar, is_h, ign, ar_p;

	assign idx      = cnt_q[IDX_W-1:0];
	assign rd_valid = e_valid_q[idx];
	assign same     = e_ip_q[idx] == cmd_q.ip && e_tp_q[idx] == cmd_q.tp &&
	                  e_itf_q[idx] == cmd_q.itf;
	assign at_end   = (cnt_q == CNT_W'(N - 1));
	assign ld       = !ov_q || out_ready;
	assign capped   = (ncnt_q >= prt_pkg::NCNT_W'(prt_pkg::MAX_NOTICES));
	assign q_take   = (state_q == S_IDLE);

	always_comb begin
		hit = rd_valid && !same;
		if (mode_q == M_PREEMPT) begin
			hit = hit && (e_key_q[idx] == cmd_q.sak || (ar_q && cmd_q.sak == 64'd0));
		end
	end

	// Holder classification and per-command decision.
	always_comb begin
		h_single = h_type_q == prt_pkg::TYPE_WR_EXCL || h_type_q == prt_pkg::TYPE_EXCL_ACCESS;
		h_ro     = h_type_q == prt_pkg::TYPE_WR_EXCL_RO || h_type_q == prt_pkg::TYPE_EXCL_RO;
		h_ar     = h_type_q == prt_pkg::TYPE_WR_EXCL_AR || h_type_q == prt_pkg::TYPE_EXCL_AR;
		reg_wk   = found_q && fkey_q == cmd_q.key;
		hid      = h_ip_q == cmd_q.ip && h_tp_q == cmd_q.tp && h_itf_q == cmd_q.itf;
		is_h     = is_res_q && ((h_single || h_ro) ? hid : (h_ar ? found_q : 1'b0));
		ign      = (cmd_q.op == prt_pkg::OP_REGISTER_IGN);
		ar_p     = is_res_q && h_ar;
		d        = '0;
		d.st     = prt_pkg::ST_GOOD;
		d.mode   = M_NONE;
		d.att    = prt_pkg::ATT_RES_RELEASED;
		d.ar     = ar_p;
		case (cmd_q.op)
			prt_pkg::OP_REGISTER, prt_pkg::OP_REGISTER_IGN: begin
				if (found_q) begin
					if (!ign && cmd_q.key != fkey_q) begin
						d.st = prt_pkg::ST_CONFLICT;
					end else begin
						d.gen_inc = 1'b1;
						if (cmd_q.sak == 64'd0) begin
							d.inv_found = 1'b1;
							if (is_res_q) begin
								if (h_ar) begin
									d.drop_res = !other_q;
								end else if ((h_single || h_ro) && hid) begin
									d.drop_res = 1'b1;
									if (h_ro) begin
										d.mode = M_OTHERS;
									end
								end
							end
						end else begin
							d.upd_key = 1'b1;
						end
					end
				end else if (cmd_q.sak == 64'd0 && (ign || cmd_q.key == 64'd0)) begin
					d.gen_inc = 1'b1;
				end else if (!ign && cmd_q.key != 64'd0) begin
					d.st = prt_pkg::ST_CONFLICT;
				end else if (!free_ok_q) begin
					d.st = prt_pkg::ST_TABLE_FULL;
				end else begin
					d.write_new = 1'b1;
					d.gen_inc   = 1'b1;
				end
			end
			prt_pkg::OP_RESERVE: begin
				if (!reg_wk || (is_res_q && !is_h) ||
				    (is_res_q && (h_key_q != cmd_q.key || h_type_q != cmd_q.rtype))) begin
					d.st = prt_pkg::ST_CONFLICT;
				end else if (!is_res_q) begin
					d.set_res    = 1'b1;
					d.set_holder = 1'b1;
				end
			end
			prt_pkg::OP_RELEASE: begin
				if (is_res_q) begin
					if (!reg_wk || !hid || h_key_q != cmd_q.key) begin
						d.st = prt_pkg::ST_CONFLICT;
					end else if (cmd_q.scope != 4'd0 || h_type_q != cmd_q.rtype) begin
						d.st = prt_pkg::ST_INV_RELEASE;
					end else begin
						d.drop_res = 1'b1;
						if (h_ro || h_ar) begin
							d.mode = M_OTHERS;
						end
					end
				end
			end
			prt_pkg::OP_CLEAR: begin
				if (!reg_wk) begin
					d.st = prt_pkg::ST_CONFLICT;
				end else begin
					d.mode     = M_OTHERS;
					d.att      = prt_pkg::ATT_RES_PREEMPTED;
					d.drop_res = 1'b1;
					d.clr_all  = 1'b1;
					d.gen_inc  = 1'b1;
				end
			end
			prt_pkg::OP_PREEMPT, prt_pkg::OP_PREEMPT_ABORT: begin
				if (!reg_wk || (is_res_q && h_key_q != cmd_q.key)) begin
					d.st = prt_pkg::ST_CONFLICT;
				end else if (!ar_p && is_res_q && cmd_q.sak == 64'd0) begin
					d.st = prt_pkg::ST_INV_FIELD;
				end else begin
					d.mode       = M_PREEMPT;
					d.att        = prt_pkg::ATT_REG_PREEMPTED;
					d.gen_inc    = 1'b1;
					d.set_holder = (is_res_q && !ar_p && h_key_q == cmd_q.sak) ||
					               (ar_p && cmd_q.sak == 64'd0);
				end
			end
			default: begin
				d.st = prt_pkg::ST_INV_FIELD;
			end
		endcase
	end

	// Scan and final step: what to emit, whether to move on, whether to drop the entry.
	always_comb begin
		emit      = 1'b0;
		emit_last = 1'b0;
		emit_kind = prt_pkg::KIND_UA;
		emit_att  = att_q;
		adv       = 1'b0;
		inv_now   = 1'b0;
		sub_set   = 1'b0;
		if (state_q == S_SCAN) begin
			if (!hit) begin
				adv = 1'b1;
			end else if (mode_q == M_PREEMPT && cmd_q.op == prt_pkg::OP_PREEMPT_ABORT &&
			             !sub_q) begin
				emit_kind = prt_pkg::KIND_ABORT;
				emit_att  = prt_pkg::ATT_RES_RELEASED;
				emit      = !capped && ld;
				sub_set   = capped || ld;
			end else if (capped || ld) begin
				emit    = !capped;
				adv     = 1'b1;
				inv_now = (mode_q == M_PREEMPT);
			end
		end else if (state_q == S_FINAL && ld) begin
			emit      = 1'b1;
			emit_last = 1'b1;
			emit_kind = prt_pkg::KIND_FINAL;
			emit_att  = prt_pkg::ATT_RES_RELEASED;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take && q_valid) begin
			cmd_q <= q_cmd;
		end
		if (state_q == S_LOOK) begin
			if (rd_valid && same && !found_q) begin
				fidx_q <= idx;
				fkey_q <= e_key_q[idx];
			end
			if (!rd_valid && !free_ok_q) begin
				free_idx_q <= idx;
			end
		end
		if (state_q == S_DECIDE) begin
			if (d.upd_key) begin
				e_key_q[fidx_q] <= cmd_q.sak;
			end
			if (d.write_new) begin
				e_ip_q[free_idx_q]  <= cmd_q.ip;
				e_tp_q[free_idx_q]  <= cmd_q.tp;
				e_rp_q[free_idx_q]  <= cmd_q.rp;
				e_itf_q[free_idx_q] <= cmd_q.itf;
				e_key_q[free_idx_q] <= cmd_q.sak;
			end
			st_q  <= d.st;
			att_q <= d.att;
			ar_q  <= d.ar;
		end
		if (emit) begin
			kind_q  <= emit_kind;
			att_o_q <= emit_last ? prt_pkg::ATT_RES_RELEASED : emit_att;
			st_o_q  <= emit_last ? st_q : prt_pkg::ST_GOOD;
			ip_o_q  <= emit_last ? 64'd0 : e_ip_q[idx];
			tp_o_q  <= emit_last ? 64'd0 : e_tp_q[idx];
			rp_o_q  <= emit_last ? 16'd0 : e_rp_q[idx];
			itf_o_q <= emit_last ? 2'd0 : e_itf_q[idx];
			gen_o_q <= gen_q;
			last_q  <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			for (int i = 0; i < N; i++) begin
				e_valid_q[i] <= 1'b0;
			end
			is_res_q  <= 1'b0;
			h_type_q  <= 4'd0;
			h_key_q   <= 64'd0;
			h_ip_q    <= 64'd0;
			h_tp_q    <= 64'd0;
			h_rp_q    <= 16'd0;
			h_itf_q   <= 2'd0;
			gen_q     <= 32'd0;
			cnt_q     <= '0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
			other_q   <= 1'b0;
			mode_q    <= M_NONE;
			clr_q     <= 1'b0;
			sub_q     <= 1'b0;
			ncnt_q    <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cnt_q     <= '0;
						found_q   <= 1'b0;
						free_ok_q <= 1'b0;
						other_q   <= 1'b0;
						state_q   <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (rd_valid && same) begin
						found_q <= 1'b1;
					end
					if (!rd_valid) begin
						free_ok_q <= 1'b1;
					end
					if (rd_valid && !same) begin
						other_q <= 1'b1;
					end
					cnt_q <= cnt_q + CNT_W'(1);
					if (at_end) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (d.inv_found) begin
						e_valid_q[fidx_q] <= 1'b0;
					end
					if (d.write_new) begin
						e_valid_q[free_idx_q] <= 1'b1;
					end
					if (d.gen_inc) begin
						gen_q <= gen_q + 32'd1;
					end
					if (d.drop_res) begin
						is_res_q <= 1'b0;
						h_type_q <= 4'd0;
						h_key_q  <= 64'd0;
					end
					if (d.set_res) begin
						is_res_q <= 1'b1;
					end
					if (d.set_holder) begin
						h_type_q <= cmd_q.rtype;
						h_key_q  <= cmd_q.key;
						h_ip_q   <= cmd_q.ip;
						h_tp_q   <= cmd_q.tp;
						h_rp_q   <= cmd_q.rp;
						h_itf_q  <= cmd_q.itf;
					end
					mode_q <= d.mode;
					clr_q  <= d.clr_all;
					cnt_q  <= '0;
					sub_q  <= 1'b0;
					ncnt_q <= '0;
					state_q <= (d.mode == M_NONE) ? S_FINAL : S_SCAN;
				end
				S_SCAN: begin
					if (emit) begin
						ncnt_q <= ncnt_q + prt_pkg::NCNT_W'(1);
					end
					if (sub_set) begin
						sub_q <= 1'b1;
					end
					if (inv_now) begin
						e_valid_q[idx] <= 1'b0;
					end
					if (adv) begin
						sub_q <= 1'b0;
						cnt_q <= cnt_q + CNT_W'(1);
						if (at_end) begin
							state_q <= S_FINAL;
						end
					end
				end
				S_FINAL: begin
					if (ld) begin
						if (clr_q) begin
							for (int i = 0; i < N; i++) begin
								e_valid_q[i] <= 1'b0;
							end
						end
						clr_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = ov_q;
	assign out_kind   = kind_q;
	assign out_status = st_o_q;
	assign out_att    = att_o_q;
	assign out_ip     = ip_o_q;
	assign out_tp     = tp_o_q;
	assign out_rp     = rp_o_q;
	assign out_itf    = itf_o_q;
	assign out_gen    = gen_o_q;
	assign out_last   = last_q;

endmodule

>>> hdl/prt_checker.sv
// Port-level checks for the persistent reservation table, bound to the top level.
// Depends on prt_pkg.
module prt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  kind,
	input logic [2:0]  status,
	input logic [31:0] generation,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("Response word dropped before it was taken.");

	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (last == (kind == prt_pkg::KIND_FINAL)))
		else $error("Final status and last flag disagree.");

	a_notice_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> status == prt_pkg::ST_GOOD)
		else $error("Notice carries a nonzero status.");

	a_gen_steady: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !last |=> $stable(generation))
		else $error("Generation changed within one command.");

endmodule

bind persistent_reservation_table prt_checker u_prt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp_valid),
	.rsp_ready  (rsp_ready),
	.kind       (kind),
	.status     (status),
	.generation (generation),
	.last       (last)
);
